### rtl/bezier_curve_evaluator_macros.svh
// ----------------------------------------------------------------------------
// Bezier curve evaluator assertion macros
// Property wrappers that compile away in synthesis.
// ----------------------------------------------------------------------------
`ifndef BEZIER_CURVE_EVALUATOR_MACROS_SVH
`define BEZIER_CURVE_EVALUATOR_MACROS_SVH

`ifndef SYNTHESIS
`define BCE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed: implication");
`define BCE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define BCE_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define BCE_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

### rtl/bce_pkg.sv
// ----------------------------------------------------------------------------
// Bezier curve evaluator package
// Shared constants, types and state encoding.
// ----------------------------------------------------------------------------
package bce_pkg;

  localparam int unsigned CURVE_ORDER = 7;
  localparam int unsigned NPTS        = CURVE_ORDER + 1;
  localparam int unsigned LVL_W       = $clog2(CURVE_ORDER + 1);
  localparam int unsigned DIV_W       = 37;
  localparam int unsigned DCNT_W      = $clog2(DIV_W);

  localparam logic        OP_LOAD = 1'b0;
  localparam logic        OP_EVAL = 1'b1;

  localparam logic [1:0]  COORD_X = 2'd0;
  localparam logic [1:0]  COORD_Y = 2'd1;
  localparam logic [1:0]  COORD_Z = 2'd2;

  localparam logic [15:0] DURATION_RESET = 16'd1000;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } point_t;

  typedef struct packed {
    logic       load_w;
    logic       step;
    logic [1:0] coord;
  } cell_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SDIV,
    ST_LOAD,
    ST_LERP,
    ST_VSTART,
    ST_VDIV,
    ST_OUT
  } state_e;

endpackage

### rtl/bce_in_if.sv
// ----------------------------------------------------------------------------
// Bezier curve evaluator input channel
// Valid/ready channel carrying load and evaluate items.
// ----------------------------------------------------------------------------
interface bce_in_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic [2:0]         point_index;
  logic signed [31:0] coord_x;
  logic signed [31:0] coord_y;
  logic signed [31:0] coord_z;
  logic [15:0]        time_tick;

  modport source (output valid, operation, point_index, coord_x, coord_y, coord_z,
                  time_tick, input ready);
  modport sink   (input valid, operation, point_index, coord_x, coord_y, coord_z,
                  time_tick, output ready);
endinterface

### rtl/bce_out_if.sv
// ----------------------------------------------------------------------------
// Bezier curve evaluator output channel
// Valid/ready channel carrying position and velocity results.
// ----------------------------------------------------------------------------
interface bce_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [31:0] vel_z;

  modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                  input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                  output ready);
endinterface

### rtl/bce_div.sv
// ----------------------------------------------------------------------------
// Bezier curve evaluator divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bce_div
  import bce_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] dividend_i,
  input  logic [15:0]      divisor_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [DIV_W-1:0] quot_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [DCNT_W-1:0] cnt_q, cnt_d;
  logic [15:0]       rem_q, rem_d;
  logic [15:0]       dvs_q, dvs_d;
  logic [DIV_W-1:0]  quo_q, quo_d;
  logic [16:0]       trial;
  logic [16:0]       trial_sub;

  always_comb begin
    trial     = {rem_q, quo_q[DIV_W-1]};
    trial_sub = trial - {1'b0, dvs_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dvs_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      // The remainder stays below the divisor, so 16 bits hold it.
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = trial_sub[15:0];
        quo_d = {quo_q[DIV_W-2:0], 1'b1};
      end else begin
        rem_d = trial[15:0];
        quo_d = {quo_q[DIV_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DCNT_W'(DIV_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

### rtl/bce_cell.sv
// ----------------------------------------------------------------------------
// Bezier curve evaluator cell
// Holds one control point and one working value of the interpolation row.
// ----------------------------------------------------------------------------
module bce_cell
  import bce_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               ld_i,
  input  point_t             pt_i,
  input  cell_ctl_t          ctl_i,
  input  logic [16:0]        s_i,
  input  logic signed [31:0] nb_i,
  output logic signed [31:0] w_o
);

  point_t             pt_q;
  logic signed [31:0] w_q, w_d;
  logic signed [32:0] delta;
  logic signed [50:0] prod;
  logic signed [50:0] rnd;

  // a*(1-s) + b*s equals a + (b-a)*s, so one multiplier serves the cell.
  always_comb begin
    delta = {nb_i[31], nb_i} - {w_q[31], w_q};
    prod  = 51'(delta) * 51'($signed({1'b0, s_i}));
    rnd   = (prod + 51'sd32768) >>> 16;
    w_d   = w_q;
    if (ctl_i.load_w) begin
      case (ctl_i.coord)
        COORD_X: w_d = pt_q.x;
        COORD_Y: w_d = pt_q.y;
        COORD_Z: w_d = pt_q.z;
        default: w_d = pt_q.x;
      endcase
    end else if (ctl_i.step) begin
      w_d = w_q + rnd[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pt_q <= '0;
    end else if (ld_i) begin
      pt_q <= pt_i;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q <= w_d;
  end

  assign w_o = w_q;

endmodule

### rtl/bezier_curve_evaluator.sv
// ----------------------------------------------------------------------------
// Bezier curve evaluator
// Degree-7 three-dimensional Bezier position and velocity, fixed point.
// ----------------------------------------------------------------------------
// Channel  Direction  Item
// in_i     sink       load a control point, or evaluate at a tick
// out_o    source     position and velocity for one evaluate item
// cfg      write      duration in ticks
//
// A load item is taken while the block is idle and gives no result.
// An evaluate item holds the block while it is accepted, while the parameter
// division runs, then per coordinate while the cell row interpolates and the
// velocity division runs, and while the result is handed over. One item is
// worked at a time.
// A finished result waits in the output register, and the next item is
// accepted meanwhile. Reset clears the control points and restores the reset
// duration.
// ----------------------------------------------------------------------------
`include "bezier_curve_evaluator_macros.svh"

module bezier_curve_evaluator
  import bce_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  bce_in_if.sink      in_i,
  bce_out_if.source   out_o
);

  state_e             state_q, state_d;
  logic [15:0]        dur_q;
  logic [15:0]        d_eff;
  logic [15:0]        tick_q, tick_d;
  logic               at_end_q, at_end_d;
  logic [16:0]        s_q, s_d;
  logic [1:0]         coord_q, coord_d;
  logic [LVL_W-1:0]   lvl_q, lvl_d;
  logic signed [32:0] diff_q, diff_d;
  logic [31:0]        pos_q [3];
  logic [31:0]        vel_q [3];
  logic               neg_q, neg_d;
  logic               out_valid_q, out_valid_d;
  logic               out_load;
  logic               in_acc;
  cell_ctl_t          ctl;
  point_t             pt_in;
  logic signed [31:0] w [NPTS];
  logic [NPTS-1:0]    ld;

  logic               div_start, div_busy, div_done;
  logic [DIV_W-1:0]   div_dividend, div_quot;
  logic signed [35:0] numer;
  logic [35:0]        mag;
  logic [31:0]        vel_sat;

  assign d_eff  = (dur_q == 16'd0) ? 16'd1 : dur_q;
  assign in_acc = in_i.valid && in_i.ready;
  assign pt_in  = '{x: in_i.coord_x, y: in_i.coord_y, z: in_i.coord_z};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dur_q <= DURATION_RESET;
    end else if (cfg_we_i) begin
      dur_q <= cfg_wdata_i;
    end
  end

  for (genvar i = 0; i < NPTS; i++) begin : g_cell
    assign ld[i] = in_acc && (in_i.operation == OP_LOAD)
                   && (in_i.point_index == 3'(i));
    bce_cell u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .ld_i  (ld[i]),
      .pt_i  (pt_in),
      .ctl_i (ctl),
      .s_i   (s_q),
      .nb_i  ((i == NPTS - 1) ? w[i] : w[(i + 1) % NPTS]),
      .w_o   (w[i])
    );
  end

  bce_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (d_eff),
    .busy_o    (div_busy),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  // Velocity numerator is CURVE_ORDER times the last difference, rounded
  // half away from zero on the magnitude.
  assign numer = 36'(diff_q) * 36'(CURVE_ORDER);
  assign mag   = numer[35] ? 36'(-numer) : 36'(numer);

  always_comb begin
    if (at_end_q) begin
      vel_sat = '0;
    end else if (!neg_q) begin
      vel_sat = (div_quot > DIV_W'(32'h7fff_ffff)) ? 32'h7fff_ffff : div_quot[31:0];
    end else begin
      vel_sat = (div_quot > DIV_W'(33'h0_8000_0000)) ? 32'h8000_0000
                                                     : 32'(-div_quot[31:0]);
    end
  end

  always_comb begin
    state_d      = state_q;
    tick_d       = tick_q;
    at_end_d     = at_end_q;
    s_d          = s_q;
    coord_d      = coord_q;
    lvl_d        = lvl_q;
    diff_d       = diff_q;
    neg_d        = neg_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_load     = 1'b0;
    ctl          = '{load_w: 1'b0, step: 1'b0, coord: coord_q};
    div_start    = 1'b0;
    div_dividend = {DIV_W{1'b0}};
    in_i.ready   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid && in_i.operation == OP_EVAL) begin
          at_end_d = in_i.time_tick >= d_eff;
          tick_d   = at_end_d ? d_eff : in_i.time_tick;
          state_d  = ST_SDIV;
        end
      end
      ST_SDIV: begin
        div_start    = !div_busy && !div_done;
        div_dividend = DIV_W'({tick_q, 16'h0000});
        if (div_done) begin
          s_d     = div_quot[16:0];
          coord_d = COORD_X;
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        ctl.load_w = 1'b1;
        lvl_d      = LVL_W'(1);
        state_d    = ST_LERP;
      end
      ST_LERP: begin
        ctl.step = 1'b1;
        lvl_d    = lvl_q + 1'b1;
        if (lvl_q == LVL_W'(CURVE_ORDER)) begin
          diff_d  = {w[1][31], w[1]} - {w[0][31], w[0]};
          state_d = ST_VSTART;
        end
      end
      ST_VSTART: begin
        div_start    = 1'b1;
        div_dividend = DIV_W'(mag) + DIV_W'(d_eff[15:1]);
        neg_d        = numer[35];
        state_d      = ST_VDIV;
      end
      ST_VDIV: begin
        if (div_done) begin
          if (coord_q == COORD_Z) begin
            state_d = ST_OUT;
          end else begin
            coord_d = coord_q + 1'b1;
            state_d = ST_LOAD;
          end
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      coord_q     <= COORD_X;
      lvl_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      coord_q     <= coord_d;
      lvl_q       <= lvl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tick_q   <= tick_d;
    at_end_q <= at_end_d;
    s_q      <= s_d;
    diff_q   <= diff_d;
    neg_q    <= neg_d;
    if (state_q == ST_VSTART) begin
      pos_q[coord_q] <= w[0];
    end
    if (state_q == ST_VDIV && div_done) begin
      vel_q[coord_q] <= vel_sat;
    end
    if (out_load) begin
      out_o.pos_x <= pos_q[0];
      out_o.pos_y <= pos_q[1];
      out_o.pos_z <= pos_q[2];
      out_o.vel_x <= vel_q[0];
      out_o.vel_y <= vel_q[1];
      out_o.vel_z <= vel_q[2];
    end
  end

  assign out_o.valid = out_valid_q;

  `BCE_ASSERT_IMP(a_div_start_idle, clk_i, rst_ni, div_start, !div_busy)
  `BCE_ASSERT_IMP(a_step_level, clk_i, rst_ni, ctl.step,
                  (lvl_q >= LVL_W'(1)) && (lvl_q <= LVL_W'(CURVE_ORDER)))
  `BCE_ASSERT_NXT(a_next_coord, clk_i, rst_ni,
                  (state_q == ST_VDIV) && div_done && (coord_q != COORD_Z),
                  state_q == ST_LOAD)

endmodule
